FILE: rtl/core/cpfm_pkg.sv
package cpfm_pkg;

  localparam int MAX_RANGES = 16;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int COUNT_W    = $clog2(MAX_RANGES + 1);

  localparam int CH_W    = 16;
  localparam int FREQ_W  = 36;
  localparam int WIDTH_W = 27;
  localparam int STEP_W  = 24;
  localparam int OFF_W   = 8;
  localparam int SLOT_W  = 4;

  localparam int PROD1_W = CH_W + WIDTH_W;
  localparam int PROD2_W = OFF_W + STEP_W + 1;
  localparam int SUM_W   = PROD1_W + 2;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_QUERY,
    CMD_SKIP
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_NEXT,
    ST_MUL,
    ST_SUM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [CH_W-1:0]         first;
    logic [CH_W-1:0]         last;
    logic [FREQ_W-1:0]       base;
    logic [WIDTH_W-1:0]      width;
    logic signed [OFF_W-1:0] low_off;
    logic signed [OFF_W-1:0] high_off;
    logic [STEP_W-1:0]       step;
  } range_entry_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [IDX_W-1:0]        slot;
    range_entry_t            range;
    logic [CH_W-1:0]         channel;
    logic signed [OFF_W-1:0] offset;
  } queue_entry_t;

  typedef struct packed {
    logic                    found;
    logic [FREQ_W-1:0]       frequency;
    logic [WIDTH_W-1:0]      bandwidth;
    logic [STEP_W-1:0]       offset_width;
    logic signed [OFF_W-1:0] lowest_offset;
    logic signed [OFF_W-1:0] highest_offset;
    logic [CH_W-1:0]         next_channel;
    logic [CH_W-1:0]         previous_channel;
  } result_t;

endpackage

FILE: rtl/core/cpfm_if.sv
interface cpfm_in_if;
  import cpfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    operation;
  logic [SLOT_W-1:0]       entry_index;
  logic [CH_W-1:0]         load_first_channel;
  logic [CH_W-1:0]         load_last_channel;
  logic [FREQ_W-1:0]       load_base_frequency;
  logic [WIDTH_W-1:0]      load_channel_width;
  logic signed [OFF_W-1:0] load_first_offset;
  logic signed [OFF_W-1:0] load_last_offset;
  logic [STEP_W-1:0]       load_offset_step;
  logic [CH_W-1:0]         channel;
  logic signed [OFF_W-1:0] offset;

  modport source (
    output valid, operation, entry_index, load_first_channel, load_last_channel,
           load_base_frequency, load_channel_width, load_first_offset,
           load_last_offset, load_offset_step, channel, offset,
    input  ready
  );

  modport sink (
    input  valid, operation, entry_index, load_first_channel, load_last_channel,
           load_base_frequency, load_channel_width, load_first_offset,
           load_last_offset, load_offset_step, channel, offset,
    output ready
  );
endinterface

interface cpfm_out_if;
  import cpfm_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [FREQ_W-1:0]       frequency;
  logic [WIDTH_W-1:0]      bandwidth;
  logic [STEP_W-1:0]       offset_width;
  logic signed [OFF_W-1:0] lowest_offset;
  logic signed [OFF_W-1:0] highest_offset;
  logic [CH_W-1:0]         next_channel;
  logic [CH_W-1:0]         previous_channel;

  modport source (
    output valid, found, frequency, bandwidth, offset_width, lowest_offset,
           highest_offset, next_channel, previous_channel,
    input  ready
  );

  modport sink (
    input  valid, found, frequency, bandwidth, offset_width, lowest_offset,
           highest_offset, next_channel, previous_channel,
    output ready
  );
endinterface

FILE: rtl/core/channel_plan_frequency_mapper.sv
// Steps: a load goes straight to its result; a query walks the range table (one slot per
//   cycle through its single read port), plus a read of the next range where needed,
//   then multiply, sum and saturate.
// Throughput: one item at a time in the back end; a 2-deep queue keeps accepting meanwhile.
// Reset: rst (synchronous) empties the queue, clears range_count and the result valid;
//   the range table keeps its contents and needs no clearing pass.
module channel_plan_frequency_mapper (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cpfm_pkg::COUNT_W-1:0] cfg_wdata,
  cpfm_in_if.sink                      item,
  cpfm_out_if.source                   result
);
  import cpfm_pkg::*;

  logic         q_valid;
  logic         q_pop;
  queue_entry_t q_data;

  cpfm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .item    (item),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  cpfm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .result    (result)
  );

  a_reset_clears_result: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid after reset");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.found) |->
      (result.frequency == '0 && result.bandwidth == '0 &&
       result.next_channel == '0 && result.previous_channel == '0))
    else $error("result without a match carries data");

endmodule

FILE: rtl/core/cpfm_front.sv
module cpfm_front (
  input  logic                  clk,
  input  logic                  rst,
  cpfm_in_if.sink               item,
  output logic                  q_valid,
  output cpfm_pkg::queue_entry_t q_data,
  input  logic                  q_pop
);
  import cpfm_pkg::*;

  queue_entry_t          slots [QUEUE_DEPTH];
  queue_entry_t          entry;
  logic [QCNT_W-1:0]     count;
  logic [QPTR_W-1:0]     wr_ptr;
  logic [QPTR_W-1:0]     rd_ptr;
  logic                  push;

  // Classify the request before it enters the queue.
  always_comb begin
    priority if (item.operation == OP_QUERY) begin
      entry.cmd = CMD_QUERY;
    end else if (int'(item.entry_index) < MAX_RANGES) begin
      entry.cmd = CMD_LOAD;
    end else begin
      entry.cmd = CMD_SKIP;
    end
    entry.slot           = IDX_W'(item.entry_index);
    entry.range.first    = item.load_first_channel;
    entry.range.last     = item.load_last_channel;
    entry.range.base     = item.load_base_frequency;
    entry.range.width    = item.load_channel_width;
    entry.range.low_off  = item.load_first_offset;
    entry.range.high_off = item.load_last_offset;
    entry.range.step     = item.load_offset_step;
    entry.channel        = item.channel;
    entry.offset         = item.offset;
  end

  assign item.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;
  assign q_valid    = (count != '0);
  assign q_data     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, q_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: rtl/core/cpfm_back.sv
module cpfm_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [cpfm_pkg::COUNT_W-1:0] cfg_wdata,
  input  logic                         q_valid,
  input  cpfm_pkg::queue_entry_t       q_data,
  output logic                         q_pop,
  cpfm_out_if.source                   result
);
  import cpfm_pkg::*;

  state_t                  state;
  state_t                  state_next;

  logic [COUNT_W-1:0]      range_count;
  logic [COUNT_W-1:0]      cnt_eff;

  range_entry_t            mem [MAX_RANGES];
  range_entry_t            rdata;
  logic [IDX_W-1:0]        rd_addr;
  logic                    mem_we;

  logic [CH_W-1:0]         ch;
  logic signed [OFF_W-1:0] off;
  logic [IDX_W-1:0]        idx;
  logic [CH_W-1:0]         prev_last;
  logic                    found;
  logic [CH_W-1:0]         diff;
  logic [FREQ_W-1:0]       base;
  logic [WIDTH_W-1:0]      width;
  logic [STEP_W-1:0]       step;
  logic signed [OFF_W-1:0] low_off;
  logic signed [OFF_W-1:0] high_off;
  logic [CH_W-1:0]         nxt;
  logic [CH_W-1:0]         prv;
  logic [PROD1_W-1:0]      prod1;
  logic signed [PROD2_W-1:0] prod2;
  logic signed [SUM_W-1:0] sum;
  logic [FREQ_W-1:0]       freq_sat;

  logic                    slot_free;
  logic                    lt_first;
  logic                    le_last;
  logic                    lt_last;
  logic                    is_last;
  logic                    res_load_zero;
  logic                    res_load_out;
  logic                    res_valid;
  result_t                 res;

  assign cnt_eff   = (int'(range_count) > MAX_RANGES) ? COUNT_W'(MAX_RANGES) : range_count;
  assign slot_free = !res_valid || result.ready;
  assign lt_first  = ch < rdata.first;
  assign le_last   = ch <= rdata.last;
  assign lt_last   = ch < rdata.last;
  assign is_last   = ({1'b0, idx} + COUNT_W'(1)) >= cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      range_count <= '0;
    end else if (cfg_we) begin
      range_count <= cfg_wdata;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (q_valid && q_data.cmd == CMD_QUERY) begin
          state_next = (cnt_eff == '0) ? ST_OUT : ST_TEST;
        end
      end
      ST_TEST: begin
        priority if (lt_first) begin
          state_next = ST_OUT;
        end else if (le_last) begin
          state_next = (lt_last || is_last) ? ST_MUL : ST_NEXT;
        end else if (is_last) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_TEST;
        end
      end
      ST_NEXT: state_next = ST_MUL;
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_OUT;
      ST_OUT: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    res_load_zero = 1'b0;
    res_load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        q_pop         = q_valid && (q_data.cmd == CMD_QUERY || slot_free);
        mem_we        = q_pop && q_data.cmd == CMD_LOAD;
        res_load_zero = q_pop && q_data.cmd != CMD_QUERY;
      end
      ST_TEST: rd_addr = idx + IDX_W'(1);
      ST_OUT:  res_load_out = slot_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Range table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_data.slot] <= q_data.range;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (q_pop && q_data.cmd == CMD_QUERY) begin
          ch        <= q_data.channel;
          off       <= q_data.offset;
          idx       <= '0;
          prev_last <= '0;
          found     <= 1'b0;
        end
      end
      ST_TEST: begin
        if (!lt_first && le_last) begin
          found    <= 1'b1;
          diff     <= ch - rdata.first;
          base     <= rdata.base;
          width    <= rdata.width;
          step     <= rdata.step;
          low_off  <= rdata.low_off;
          high_off <= rdata.high_off;
          nxt      <= lt_last ? ch + CH_W'(1) : '0;
          priority if (ch > rdata.first) begin
            prv <= ch - CH_W'(1);
          end else if (idx == '0) begin
            prv <= '0;
          end else begin
            prv <= prev_last;
          end
        end else if (!lt_first) begin
          prev_last <= rdata.last;
          idx       <= idx + IDX_W'(1);
        end
      end
      // Cross the gap into the following range.
      ST_NEXT: nxt <= rdata.first;
      ST_MUL: begin
        prod1 <= diff * width;
        prod2 <= off * $signed({1'b0, step});
      end
      ST_SUM: sum <= $signed(SUM_W'(base)) + $signed(SUM_W'(prod1)) + SUM_W'(prod2);
      default: begin
        found <= found;
      end
    endcase
  end

  // Clamp to 0 .. 2^36-1
  always_comb begin
    priority if (sum[SUM_W-1]) begin
      freq_sat = '0;
    end else if (|sum[SUM_W-2:FREQ_W]) begin
      freq_sat = '1;
    end else begin
      freq_sat = sum[FREQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load_zero || res_load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load_zero || (res_load_out && !found)) begin
      res <= '0;
    end else if (res_load_out) begin
      res.found            <= 1'b1;
      res.frequency        <= freq_sat;
      res.bandwidth        <= width;
      res.offset_width     <= step;
      res.lowest_offset    <= low_off;
      res.highest_offset   <= high_off;
      res.next_channel     <= nxt;
      res.previous_channel <= prv;
    end
  end

  assign result.valid            = res_valid;
  assign result.found            = res.found;
  assign result.frequency        = res.frequency;
  assign result.bandwidth        = res.bandwidth;
  assign result.offset_width     = res.offset_width;
  assign result.lowest_offset    = res.lowest_offset;
  assign result.highest_offset   = res.highest_offset;
  assign result.next_channel     = res.next_channel;
  assign result.previous_channel = res.previous_channel;

endmodule
